@@ sv/bfba_pkg.sv @@
package bfba_pkg;

   // defaults for the top level parameters
   localparam int TABLE_DEPTH_DEFAULT = 16;
   localparam int SIZE_BITS_DEFAULT   = 16;

   // fixed field widths of the channels
   localparam int MODE_W   = 2;
   localparam int POS_W    = 8;
   localparam int FIELD_W  = 16;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 4;
   localparam int COUNT_W  = 5;

   typedef enum logic [MODE_W-1:0] {
      MODE_FRONT  = 2'd0,
      MODE_BACK   = 2'd1,
      MODE_INSERT = 2'd2,
      MODE_FIT    = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE   = 2'd0,
      STATUS_NO_FIT = 2'd1,
      STATUS_FULL   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIT_WRITE,
      ST_SHIFT,
      ST_PLACE,
      ST_RESP
   } state_type;

   // sequencer to best fit unit
   typedef struct packed {
      logic clear;
      logic sample;
   } fit_ctrl_type;

endpackage

@@ sv/bfba_if.sv @@
// request channel
interface bfba_req_if;
   logic                          valid;
   logic                          ready;
   logic [bfba_pkg::MODE_W-1:0]   mode;
   logic [bfba_pkg::POS_W-1:0]    position;
   logic [bfba_pkg::FIELD_W-1:0]  block_size;
   logic [bfba_pkg::FIELD_W-1:0]  request_size;

   modport source (output valid, mode, position, block_size, request_size, input ready);
   modport sink   (input valid, mode, position, block_size, request_size, output ready);
endinterface

// response channel
interface bfba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bfba_pkg::STATUS_W-1:0] status;
   logic [bfba_pkg::SLOT_W-1:0]   slot;
   logic [bfba_pkg::FIELD_W-1:0]  remaining;
   logic [bfba_pkg::COUNT_W-1:0]  block_count;

   modport source (output valid, status, slot, remaining, block_count, input ready);
   modport sink   (input valid, status, slot, remaining, block_count, output ready);
endinterface

@@ sv/bfba_table.sv @@
module bfba_table #(
   parameter int DEPTH = bfba_pkg::TABLE_DEPTH_DEFAULT,
   parameter int WIDTH = bfba_pkg::SIZE_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // single registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/bfba_fit_unit.sv @@
module bfba_fit_unit #(
   parameter int DEPTH     = bfba_pkg::TABLE_DEPTH_DEFAULT,
   parameter int SIZE_BITS = bfba_pkg::SIZE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bfba_pkg::fit_ctrl_type        ctrl,
   input  logic [SIZE_BITS-1:0]          sample_size,
   input  logic [$clog2(DEPTH)-1:0]      sample_slot,
   input  logic [bfba_pkg::FIELD_W-1:0]  request,
   output logic                          found,
   output logic [$clog2(DEPTH)-1:0]      best_slot,
   output logic [SIZE_BITS-1:0]          remainder
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = (SIZE_BITS > bfba_pkg::FIELD_W) ? SIZE_BITS : bfba_pkg::FIELD_W;

   logic                 found_ff, found_in;
   logic [SIZE_BITS-1:0] best_size_ff, best_size_in;
   logic [AW-1:0]        best_slot_ff, best_slot_in;
   logic                 hit;

   // candidate fits and is strictly smaller than the best so far
   assign hit = (CW'(sample_size) >= CW'(request)) &&
                (!found_ff || (sample_size < best_size_ff));

   // best tracking
   always_comb begin
      found_in     = found_ff;
      best_size_in = best_size_ff;
      best_slot_in = best_slot_ff;
      if (ctrl.clear) begin
         found_in = 1'b0;
      end else if (ctrl.sample && hit) begin
         found_in     = 1'b1;
         best_size_in = sample_size;
         best_slot_in = sample_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_size_ff <= best_size_in;
      best_slot_ff <= best_slot_in;
   end

   // remainder of the chosen block, wraps to the stored width
   assign remainder = best_size_ff - SIZE_BITS'(request);
   assign found     = found_ff;
   assign best_slot = best_slot_ff;

endmodule

@@ sv/best_fit_block_allocator_top.sv @@
// sequence: an add writes its entry in ST_PLACE, after ST_SHIFT has moved any later entries up;
// a full table goes straight to ST_RESP; a best fit request reads every entry in ST_SCAN and
// writes a found block's remainder back in ST_FIT_WRITE before ST_RESP
// throughput: one item at a time, set by the single read port of the size table, which the
// scan and the shift walk one entry per cycle; ready again the cycle after the result is queued
// reset: synchronous, clears the entry count, state and valid flags, not the size table
module best_fit_block_allocator_top #(
   parameter int TABLE_DEPTH = bfba_pkg::TABLE_DEPTH_DEFAULT,
   parameter int SIZE_BITS   = bfba_pkg::SIZE_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   bfba_req_if.sink    req_if,
   bfba_rsp_if.source  rsp_if
);

   localparam int AW   = $clog2(TABLE_DEPTH);
   localparam int CNTW = $clog2(TABLE_DEPTH + 1);
   localparam int PW   = (CNTW > bfba_pkg::POS_W) ? CNTW : bfba_pkg::POS_W;

   bfba_pkg::state_type   state_ff, state_in;
   logic [CNTW-1:0]       count_ff, count_in;
   logic [SIZE_BITS-1:0]  bsize_ff, bsize_in;
   logic [bfba_pkg::FIELD_W-1:0] req_size_ff, req_size_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic                  issue_ff, issue_in;
   logic                  rvalid_ff, rvalid_in;
   logic [AW-1:0]         ridx_ff, ridx_in;
   logic [AW-1:0]         place_ff, place_in;

   bfba_pkg::status_type          res_status_ff, res_status_in;
   logic [bfba_pkg::SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic [bfba_pkg::FIELD_W-1:0]  res_rem_ff, res_rem_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   bfba_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [bfba_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [bfba_pkg::FIELD_W-1:0]  rsp_rem_ff, rsp_rem_in;
   logic [bfba_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic                  req_ready;
   logic                  mem_wr_en;
   logic [AW-1:0]         mem_wr_addr;
   logic [SIZE_BITS-1:0]  mem_wr_data;
   logic                  mem_rd_en;
   logic [AW-1:0]         mem_rd_addr;
   logic [SIZE_BITS-1:0]  mem_rd_data;

   bfba_pkg::fit_ctrl_type fit_ctrl;
   logic                   fit_found;
   logic [AW-1:0]          fit_slot;
   logic [SIZE_BITS-1:0]   fit_remainder;

   bfba_pkg::mode_type    in_mode;
   logic                  count_full;
   logic                  pos_at_end;
   logic [AW-1:0]         place_pos;
   logic                  needs_shift;

   // size table
   bfba_table #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (SIZE_BITS)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // compare and subtract unit of the best fit scan
   bfba_fit_unit #(
      .DEPTH     (TABLE_DEPTH),
      .SIZE_BITS (SIZE_BITS)
   ) u_fit (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (fit_ctrl),
      .sample_size (mem_rd_data),
      .sample_slot (ridx_ff),
      .request     (req_size_ff),
      .found       (fit_found),
      .best_slot   (fit_slot),
      .remainder   (fit_remainder)
   );

   // target slot of an add, decided at the request transfer
   assign in_mode    = bfba_pkg::mode_type'(req_if.mode);
   assign count_full = (count_ff == CNTW'(TABLE_DEPTH));
   assign pos_at_end = (PW'(req_if.position) >= PW'(count_ff));

   always_comb begin
      if ((in_mode == bfba_pkg::MODE_FRONT) ||
          ((in_mode == bfba_pkg::MODE_INSERT) && (count_ff == '0))) begin
         place_pos = '0;
      end else if ((in_mode == bfba_pkg::MODE_BACK) || pos_at_end) begin
         place_pos = AW'(count_ff);
      end else begin
         place_pos = AW'(req_if.position) + AW'(1);
      end
   end

   assign needs_shift = (CNTW'(place_pos) < count_ff);

   // sequencer: next state and datapath control
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      bsize_in      = bsize_ff;
      req_size_in   = req_size_ff;
      idx_in        = idx_ff;
      issue_in      = issue_ff;
      rvalid_in     = 1'b0;
      ridx_in       = ridx_ff;
      place_in      = place_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_rem_in    = res_rem_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_rem_in    = rsp_rem_ff;
      rsp_count_in  = rsp_count_ff;
      req_ready     = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = ridx_ff + AW'(1);
      mem_wr_data   = mem_rd_data;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = idx_ff;
      fit_ctrl      = '0;

      case (state_ff)
         bfba_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_if.valid) begin
               bsize_in    = SIZE_BITS'(req_if.block_size);
               req_size_in = req_if.request_size;
               idx_in      = '0;
               issue_in    = 1'b0;
               if (in_mode == bfba_pkg::MODE_FIT) begin
                  fit_ctrl.clear = 1'b1;
                  issue_in       = (count_ff != '0);
                  state_in       = bfba_pkg::ST_SCAN;
               end else if (count_full) begin
                  res_status_in = bfba_pkg::STATUS_FULL;
                  res_slot_in   = '0;
                  res_rem_in    = '0;
                  state_in      = bfba_pkg::ST_RESP;
               end else begin
                  place_in      = place_pos;
                  res_status_in = bfba_pkg::STATUS_DONE;
                  res_slot_in   = bfba_pkg::SLOT_W'(place_pos);
                  res_rem_in    = '0;
                  if (needs_shift) begin
                     idx_in   = AW'(count_ff - CNTW'(1));
                     issue_in = 1'b1;
                     state_in = bfba_pkg::ST_SHIFT;
                  end else begin
                     state_in = bfba_pkg::ST_PLACE;
                  end
               end
            end
         end

         // read entries front to back, compare one per cycle
         bfba_pkg::ST_SCAN: begin
            if (issue_ff) begin
               mem_rd_en = 1'b1;
               rvalid_in = 1'b1;
               ridx_in   = idx_ff;
               if ((CNTW'(idx_ff) + CNTW'(1)) == count_ff) begin
                  issue_in = 1'b0;
               end else begin
                  idx_in = idx_ff + AW'(1);
               end
            end
            fit_ctrl.sample = rvalid_ff;
            if (!issue_ff && !rvalid_ff) begin
               state_in = bfba_pkg::ST_FIT_WRITE;
            end
         end

         // write back the chosen block, or report no fit
         bfba_pkg::ST_FIT_WRITE: begin
            if (fit_found) begin
               mem_wr_en     = 1'b1;
               mem_wr_addr   = fit_slot;
               mem_wr_data   = fit_remainder;
               res_status_in = bfba_pkg::STATUS_DONE;
               res_slot_in   = bfba_pkg::SLOT_W'(fit_slot);
               res_rem_in    = bfba_pkg::FIELD_W'(fit_remainder);
            end else begin
               res_status_in = bfba_pkg::STATUS_NO_FIT;
               res_slot_in   = '0;
               res_rem_in    = '0;
            end
            state_in = bfba_pkg::ST_RESP;
         end

         // move entries up one, back to front
         bfba_pkg::ST_SHIFT: begin
            if (issue_ff) begin
               mem_rd_en = 1'b1;
               rvalid_in = 1'b1;
               ridx_in   = idx_ff;
               if (idx_ff == place_ff) begin
                  issue_in = 1'b0;
               end else begin
                  idx_in = idx_ff - AW'(1);
               end
            end
            if (rvalid_ff) begin
               mem_wr_en = 1'b1;
            end
            if (!issue_ff && rvalid_ff) begin
               state_in = bfba_pkg::ST_PLACE;
            end
         end

         bfba_pkg::ST_PLACE: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = place_ff;
            mem_wr_data = bsize_ff;
            count_in    = count_ff + CNTW'(1);
            state_in    = bfba_pkg::ST_RESP;
         end

         // hand the result to the output register once it is free
         bfba_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_rem_in    = res_rem_ff;
               rsp_count_in  = bfba_pkg::COUNT_W'(count_ff);
               state_in      = bfba_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = bfba_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfba_pkg::ST_IDLE;
         count_ff     <= '0;
         issue_ff     <= 1'b0;
         rvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         rvalid_ff    <= rvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      bsize_ff      <= bsize_in;
      req_size_ff   <= req_size_in;
      idx_ff        <= idx_in;
      ridx_ff       <= ridx_in;
      place_ff      <= place_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_rem_ff    <= res_rem_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_rem_ff    <= rsp_rem_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // channel ports
   assign req_if.ready       = req_ready;
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.slot        = rsp_slot_ff;
   assign rsp_if.remaining   = rsp_rem_ff;
   assign rsp_if.block_count = rsp_count_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |->
         ((count_ff == ($past(count_ff) + CNTW'(1))) && ($past(state_ff) == bfba_pkg::ST_PLACE)))
      else $error("entry count changed other than by one placement");

   a_shift_above: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == bfba_pkg::ST_SHIFT) && rvalid_ff) |-> (ridx_ff >= place_ff))
      else $error("shift moved an entry below the insertion slot");

   a_fit_write: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == bfba_pkg::ST_FIT_WRITE) && mem_wr_en) |-> fit_found)
      else $error("best fit write without a chosen block");

   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == bfba_pkg::ST_RESP) && rsp_valid_ff && !rsp_if.ready) |=>
         (state_ff == bfba_pkg::ST_RESP))
      else $error("result left while the output register was busy");
`endif

endmodule

@@ tb/bfba_checker.sv @@
// watches both channels, tracks the free-block table and compares every response
module bfba_checker (
   input  logic clock,
   input  logic reset,
   bfba_req_if  req_ch,
   bfba_rsp_if  rsp_ch,
   output int   fail_count,
   output int   pending
);
   import bfba_pkg::*;

   localparam int TABLE_DEPTH = TABLE_DEPTH_DEFAULT;
   localparam int SIZE_BITS   = SIZE_BITS_DEFAULT;

   typedef struct packed {
      status_type          status;
      logic [SLOT_W-1:0]   slot;
      logic [FIELD_W-1:0]  remaining;
      logic [COUNT_W-1:0]  block_count;
   } reply_type;

   // shadow copy of the free-block table
   logic [SIZE_BITS-1:0] hole_size [TABLE_DEPTH];
   int                   hole_count;
   reply_type            awaited_replies [$];

   task automatic report_fault(input string msg);
      $display("bfba_checker: %s", msg);
      fail_count++;
   endtask

   // apply one request to the shadow table and return the reply it must produce
   function automatic reply_type serve_item(input mode_type mode,
                                            input logic [POS_W-1:0] position,
                                            input logic [FIELD_W-1:0] bsize,
                                            input logic [FIELD_W-1:0] ask);
      reply_type rep;
      bit        found;
      int        best;
      int        pos;
      rep        = '0;
      rep.status = STATUS_DONE;
      found      = 1'b0;
      best       = 0;
      pos        = 0;
      if (mode == MODE_FIT) begin
         // best fit: smallest block at or above the request, first one on a tie
         for (int k = 0; k < hole_count; k++) begin
            if (hole_size[k] >= ask && (!found || hole_size[k] < hole_size[best])) begin
               found = 1'b1;
               best  = k;
            end
         end
         if (found) begin
            hole_size[best] = hole_size[best] - SIZE_BITS'(ask);
            rep.slot        = SLOT_W'(best);
            rep.remaining   = FIELD_W'(hole_size[best]);
         end else begin
            rep.status = STATUS_NO_FIT;
         end
      end else if (hole_count >= TABLE_DEPTH) begin
         rep.status = STATUS_FULL;
      end else begin
         // pick the target slot, then shift later entries up
         if (mode == MODE_FRONT || (mode == MODE_INSERT && hole_count == 0))
            pos = 0;
         else if (mode == MODE_BACK || int'(position) >= hole_count)
            pos = hole_count;
         else
            pos = int'(position) + 1;
         for (int k = hole_count; k > pos; k--)
            hole_size[k] = hole_size[k-1];
         hole_size[pos] = SIZE_BITS'(bsize);
         hole_count++;
         rep.slot = SLOT_W'(pos);
      end
      rep.block_count = COUNT_W'(hole_count);
      return rep;
   endfunction

   // response transfers are matched before request transfers of the same edge
   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         hole_count = 0;
         awaited_replies.delete();
         pending <= 0;
      end else begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (awaited_replies.size() == 0) begin
               report_fault("response transfer with no request outstanding");
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_ch.status !== want.status)
                  report_fault($sformatf("status got %0h want %0h", rsp_ch.status, want.status));
               if (rsp_ch.slot !== want.slot)
                  report_fault($sformatf("slot got %0h want %0h", rsp_ch.slot, want.slot));
               if (rsp_ch.remaining !== want.remaining)
                  report_fault($sformatf("remaining got %0h want %0h",
                                         rsp_ch.remaining, want.remaining));
               if (rsp_ch.block_count !== want.block_count)
                  report_fault($sformatf("block_count got %0h want %0h",
                                         rsp_ch.block_count, want.block_count));
            end
         end
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            awaited_replies.push_back(serve_item(mode_type'(req_ch.mode), req_ch.position,
                                                 req_ch.block_size, req_ch.request_size));
         pending <= awaited_replies.size();
      end
   end

endmodule

@@ tb/tb_best_fit_block_allocator_top.sv @@
module tb_best_fit_block_allocator_top;
   import bfba_pkg::*;

   localparam int RANDOM_ITEMS = 1800;
   localparam int CALM_ITEMS   = 200;
   localparam int CYCLE_LIMIT  = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic calm  = 1'b0;
   int   stall_left  = 0;
   int   cycle_count = 0;
   int   fail_count;
   int   pending;

   bfba_req_if req_ch ();
   bfba_rsp_if rsp_ch ();

   best_fit_block_allocator_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   bfba_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // response side stalls in random bursts while not calm
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= $urandom_range(0, 4);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // hold one request until its transfer, then maybe idle for a burst
   task automatic transfer_item(input mode_type mode, input logic [POS_W-1:0] position,
                                input logic [FIELD_W-1:0] bsize,
                                input logic [FIELD_W-1:0] ask);
      req_ch.valid        <= 1'b1;
      req_ch.mode         <= mode;
      req_ch.position     <= position;
      req_ch.block_size   <= bsize;
      req_ch.request_size <= ask;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // stop sending until every outstanding response has come back
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      mode_type           mode;
      logic [POS_W-1:0]   position;
      logic [FIELD_W-1:0] bsize;
      logic [FIELD_W-1:0] ask;
      int                 add_pct;

      req_ch.valid        <= 1'b0;
      req_ch.mode         <= MODE_FRONT;
      req_ch.position     <= '0;
      req_ch.block_size   <= '0;
      req_ch.request_size <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, every add flavor, zero and tied requests, no fit
      transfer_item(MODE_FIT,    8'h00, 16'h0000, 16'h0000);
      transfer_item(MODE_INSERT, 8'hFF, 16'h1234, 16'h0000);
      transfer_item(MODE_FRONT,  8'h00, 16'hFFFF, 16'hFFFF);
      transfer_item(MODE_BACK,   8'hFF, 16'h0000, 16'h0000);
      transfer_item(MODE_INSERT, 8'h00, 16'h8000, 16'h0000);
      transfer_item(MODE_INSERT, 8'h04, 16'd300,  16'h0000);
      transfer_item(MODE_INSERT, 8'hFF, 16'd300,  16'h0000);
      transfer_item(MODE_FIT,    8'h00, 16'h0000, 16'h0000);
      transfer_item(MODE_FIT,    8'h00, 16'h0000, 16'd300);
      transfer_item(MODE_FIT,    8'h00, 16'h0000, 16'hFFFF);
      transfer_item(MODE_FIT,    8'h00, 16'h0000, 16'h8001);
      transfer_item(MODE_FIT,    8'h00, 16'h0000, 16'h5555);
      transfer_item(MODE_FRONT,  8'h00, 16'hAAAA, 16'h0000);
      transfer_item(MODE_INSERT, 8'h02, 16'h5555, 16'h0000);

      // random: adds dominate for the first 40 items, then mostly best fit requests
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm <= (n >= RANDOM_ITEMS - CALM_ITEMS);
         if (n == RANDOM_ITEMS / 2)
            drain();
         add_pct = (n < 40) ? 70 : 15;
         if ($urandom_range(0, 99) < add_pct)
            mode = mode_type'($urandom_range(0, 2));
         else
            mode = MODE_FIT;
         if ($urandom_range(0, 3) == 0)
            position = POS_W'($urandom_range(0, 255));
         else
            position = POS_W'($urandom_range(0, 15));
         case ($urandom_range(0, 7))
            0: bsize = 16'h0000;
            1: bsize = 16'hFFFF;
            default: bsize = FIELD_W'($urandom_range(0, 65535));
         endcase
         case ($urandom_range(0, 9))
            0: ask = 16'h0000;
            1: ask = 16'hFFFF;
            2, 3, 4, 5: ask = FIELD_W'($urandom_range(0, 255));
            6, 7: ask = FIELD_W'($urandom_range(0, 4095));
            default: ask = FIELD_W'($urandom_range(0, 65535));
         endcase
         transfer_item(mode, position, bsize, ask);
      end

      drain();
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
